>>> sv/bbr_pkg.sv
`timescale 1ns / 1ps
// bbr_pkg: shared types, constants and the divisor reciprocal table for the box blur
// used by the controller, the datapath, the stream interfaces and the top level

package bbr_pkg;

    localparam int PIX_W      = 8;
    localparam int RGB_W      = 3 * PIX_W;
    localparam int IMG_W_W    = 11;
    localparam int IMG_H_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int SUM_W      = 12;
    localparam int CNT_W      = 4;
    localparam int RECIP_W    = 16;
    localparam int RECIP_SHIFT = 15;
    localparam int PROD_W     = SUM_W + RECIP_W;

    localparam int MAX_WIDTH_DEFAULT = 1024;

    localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RESET  = 11'd640;
    localparam logic [IMG_H_W-1:0] IMAGE_HEIGHT_RESET = 16'd480;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SUM,
        ST_MUL,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic accept;
        logic shift;
        logic sum;
        logic mul;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic primed;
        logic out_free;
    } t_status;

    // ceil(2^15 / n): exact truncating quotient for sums up to 9 * 255
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
        logic [RECIP_W-1:0] r;
        case (n)
            4'd2:    r = 16'd16384;
            4'd3:    r = 16'd10923;
            4'd4:    r = 16'd8192;
            4'd5:    r = 16'd6554;
            4'd6:    r = 16'd5462;
            4'd7:    r = 16'd4682;
            4'd8:    r = 16'd4096;
            4'd9:    r = 16'd3641;
            default: r = 16'd32768;
        endcase
        return r;
    endfunction

endpackage

>>> sv/bbr_in_if.sv
`timescale 1ns / 1ps
// bbr_in_if: input pixel stream, valid/ready with rgb payload and flush mark
// depends on bbr_pkg

interface bbr_in_if;
    logic                     valid;
    logic                     ready;
    logic [bbr_pkg::PIX_W-1:0] red_in;
    logic [bbr_pkg::PIX_W-1:0] green_in;
    logic [bbr_pkg::PIX_W-1:0] blue_in;
    logic                     flush;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    output flush, input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    input flush, output ready);
endinterface

>>> sv/bbr_out_if.sv
`timescale 1ns / 1ps
// bbr_out_if: output pixel stream, valid/ready with rgb payload and frame end mark
// depends on bbr_pkg

interface bbr_out_if;
    logic                     valid;
    logic                     ready;
    logic [bbr_pkg::PIX_W-1:0] red_out;
    logic [bbr_pkg::PIX_W-1:0] green_out;
    logic [bbr_pkg::PIX_W-1:0] blue_out;
    logic                     frame_last;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output frame_last, input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    input frame_last, output ready);
endinterface

>>> sv/bbr_ram.sv
`timescale 1ns / 1ps
// bbr_ram: generic single-write, single-read ram with registered read data
// no dependencies

module bbr_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/bbr_ctrl.sv
`timescale 1ns / 1ps
// bbr_ctrl: sequencer for one pixel at a time: accept, line update, sum, multiply, emit
// depends on bbr_pkg

module bbr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  bbr_pkg::t_status i_status,
    output bbr_pkg::t_cmd    o_cmd
);

    bbr_pkg::t_state r_state;
    bbr_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bbr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            bbr_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = bbr_pkg::ST_LOAD;
                end
            end
            bbr_pkg::ST_LOAD: begin
                o_cmd.shift = 1'b1;
                n_state     = i_status.primed ? bbr_pkg::ST_SUM : bbr_pkg::ST_IDLE;
            end
            bbr_pkg::ST_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = bbr_pkg::ST_MUL;
            end
            bbr_pkg::ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = bbr_pkg::ST_OUT;
            end
            bbr_pkg::ST_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = bbr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bbr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> sv/bbr_dp.sv
`timescale 1ns / 1ps
// bbr_dp: config registers, position counters, line store, 3x3 window, sum and divide
// depends on bbr_pkg and bbr_ram

module bbr_dp #(
    parameter int MAX_WIDTH = bbr_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bbr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bbr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [bbr_pkg::PIX_W-1:0]       i_red,
    input  logic [bbr_pkg::PIX_W-1:0]       i_green,
    input  logic [bbr_pkg::PIX_W-1:0]       i_blue,
    input  logic                            i_flush,
    input  logic                            i_out_ready,
    input  bbr_pkg::t_cmd                   i_cmd,
    output bbr_pkg::t_status                o_status,
    output logic                            o_out_valid,
    output logic [bbr_pkg::PIX_W-1:0]       o_red,
    output logic [bbr_pkg::PIX_W-1:0]       o_green,
    output logic [bbr_pkg::PIX_W-1:0]       o_blue,
    output logic                            o_frame_last
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int PW = bbr_pkg::PIX_W;
    localparam int XW = bbr_pkg::RGB_W;
    localparam int HW = bbr_pkg::IMG_H_W;

    logic [bbr_pkg::IMG_W_W-1:0] r_image_width, n_image_width;
    logic [HW-1:0]               r_image_height, n_image_height;
    logic [CW-1:0]               r_in_column, n_in_column;
    logic [HW-1:0]               r_in_row, n_in_row;
    logic [CW-1:0]               r_out_column, n_out_column;
    logic [HW-1:0]               r_out_row, n_out_row;
    logic [XW-1:0]               r_pix;
    logic [XW-1:0]               r_win [9];
    logic [bbr_pkg::SUM_W-1:0]   r_sum [3];
    logic [bbr_pkg::SUM_W-1:0]   n_sum [3];
    logic [bbr_pkg::RECIP_W-1:0] r_recip;
    logic                        r_last;
    logic [bbr_pkg::PROD_W-1:0]  r_prod [3];
    logic                        r_prod_last;
    logic                        r_out_valid;
    logic [PW-1:0]               r_out_rgb [3];
    logic                        r_out_last;

    logic [2*XW-1:0] w_rd;
    logic [WW-1:0]   w_width;
    logic [HW-1:0]   w_height;
    logic [WW-1:0]   w_in_col_p1;
    logic [WW-1:0]   w_out_col_p1;
    logic [HW:0]     w_out_row_p1;
    logic            w_primed;
    logic            w_top_ok, w_bot_ok, w_left_ok, w_right_ok, w_last;
    logic [2:0]      w_row_ok, w_col_ok;
    logic [bbr_pkg::CNT_W-1:0] w_count;

    bbr_ram #(
        .WIDTH (2 * XW),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.shift),
        .i_waddr (r_in_column),
        .i_wdata ({w_rd[XW-1:0], r_pix}),
        .i_re    (i_cmd.accept),
        .i_raddr (r_in_column),
        .o_rdata (w_rd)
    );

    // effective frame size
    always_comb begin
        if (r_image_width == '0) begin
            w_width = WW'(1);
        end else if (32'(r_image_width) > MAX_WIDTH) begin
            w_width = WW'(MAX_WIDTH);
        end else begin
            w_width = WW'(r_image_width);
        end
        w_height = (r_image_height == '0) ? HW'(1) : r_image_height;
    end

    assign w_in_col_p1  = WW'(r_in_column) + WW'(1);
    assign w_out_col_p1 = WW'(r_out_column) + WW'(1);
    assign w_out_row_p1 = (HW+1)'(r_out_row) + (HW+1)'(1);
    assign w_primed     = (r_in_row >= HW'(2)) || (r_in_row == HW'(1) && r_in_column != '0);

    assign w_top_ok   = r_out_row != '0;
    assign w_bot_ok   = w_out_row_p1 < (HW+1)'(w_height);
    assign w_left_ok  = r_out_column != '0;
    assign w_right_ok = w_out_col_p1 < w_width;
    assign w_last     = !w_bot_ok && !w_right_ok;
    assign w_row_ok   = {w_bot_ok, 1'b1, w_top_ok};
    assign w_col_ok   = {w_right_ok, 1'b1, w_left_ok};
    assign w_count    = (bbr_pkg::CNT_W'(2'd1) + bbr_pkg::CNT_W'(w_top_ok)
                         + bbr_pkg::CNT_W'(w_bot_ok))
                      * (bbr_pkg::CNT_W'(2'd1) + bbr_pkg::CNT_W'(w_left_ok)
                         + bbr_pkg::CNT_W'(w_right_ok));

    // masked neighbourhood sums
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            n_sum[ch] = '0;
            for (int rr = 0; rr < 3; rr++) begin
                for (int cc = 0; cc < 3; cc++) begin
                    if (w_row_ok[rr] && w_col_ok[cc]) begin
                        n_sum[ch] = n_sum[ch]
                                  + bbr_pkg::SUM_W'(r_win[rr*3+cc][(2-ch)*PW +: PW]);
                    end
                end
            end
        end
    end

    // config and position counters
    always_comb begin
        n_image_width  = r_image_width;
        n_image_height = r_image_height;
        n_in_column    = r_in_column;
        n_in_row       = r_in_row;
        n_out_column   = r_out_column;
        n_out_row      = r_out_row;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bbr_pkg::CFG_IMAGE_WIDTH:  n_image_width  = i_cfg_data[bbr_pkg::IMG_W_W-1:0];
                bbr_pkg::CFG_IMAGE_HEIGHT: n_image_height = i_cfg_data[HW-1:0];
                default: ;
            endcase
        end
        if (i_cmd.shift) begin
            if (w_in_col_p1 >= w_width) begin
                n_in_column = '0;
                if (r_in_row != '1) begin
                    n_in_row = r_in_row + HW'(1);
                end
            end else begin
                n_in_column = w_in_col_p1[CW-1:0];
            end
        end
        if (i_cmd.sum) begin
            if (w_last) begin
                n_in_column  = '0;
                n_in_row     = '0;
                n_out_column = '0;
                n_out_row    = '0;
            end else if (!w_right_ok) begin
                n_out_column = '0;
                n_out_row    = w_out_row_p1[HW-1:0];
            end else begin
                n_out_column = w_out_col_p1[CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= bbr_pkg::IMAGE_WIDTH_RESET;
            r_image_height <= bbr_pkg::IMAGE_HEIGHT_RESET;
            r_in_column    <= '0;
            r_in_row       <= '0;
            r_out_column   <= '0;
            r_out_row      <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_image_width  <= n_image_width;
            r_image_height <= n_image_height;
            r_in_column    <= n_in_column;
            r_in_row       <= n_in_row;
            r_out_column   <= n_out_column;
            r_out_row      <= n_out_row;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pix <= i_flush ? '0 : {i_red, i_green, i_blue};
        end
        if (i_cmd.shift) begin
            for (int rr = 0; rr < 3; rr++) begin
                r_win[rr*3]   <= r_win[rr*3+1];
                r_win[rr*3+1] <= r_win[rr*3+2];
            end
            r_win[2] <= w_rd[2*XW-1:XW];
            r_win[5] <= w_rd[XW-1:0];
            r_win[8] <= r_pix;
        end
        if (i_cmd.sum) begin
            r_sum   <= n_sum;
            r_recip <= bbr_pkg::recip(w_count);
            r_last  <= w_last;
        end
        if (i_cmd.mul) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_prod[ch] <= bbr_pkg::PROD_W'(r_sum[ch]) * bbr_pkg::PROD_W'(r_recip);
            end
            r_prod_last <= r_last;
        end
        if (i_cmd.emit) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_out_rgb[ch] <= r_prod[ch][bbr_pkg::RECIP_SHIFT +: PW];
            end
            r_out_last <= r_prod_last;
        end
    end

    assign o_status.primed   = w_primed;
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid  = r_out_valid;
    assign o_red        = r_out_rgb[0];
    assign o_green      = r_out_rgb[1];
    assign o_blue       = r_out_rgb[2];
    assign o_frame_last = r_out_last;

`ifndef NO_ASSERTIONS
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over a beat not yet taken");

    a_accept_then_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.accept |=> (i_cmd.shift && !i_cmd.accept))
        else $error("line update missing after accepted beat");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.sum && w_last) |=> (r_in_column == '0 && r_in_row == '0
                                   && r_out_column == '0 && r_out_row == '0))
        else $error("counters not cleared after frame end");
`endif

endmodule

>>> sv/box_blur_3x3_rgb.sv
`timescale 1ns / 1ps
// box_blur_3x3_rgb: top level of the streaming 3x3 rgb box blur
// depends on bbr_pkg, bbr_in_if, bbr_out_if, bbr_ctrl, bbr_dp, bbr_ram
//
//   channel   dir  payload                                    handshake
//   i_pix     in   red_in, green_in, blue_in, flush           valid/ready
//   o_pix     out  red_out, green_out, blue_out, frame_last   valid/ready
//   i_cfg_*   in   index 0 image_width, 1 image_height        i_cfg_we, no wait
//
// an item with no result goes through accept and line store update; an item with a result
// goes on through window sum, reciprocal multiply and output load, and the output load
// waits until the output register is free.
// reset is synchronous: counters and output valid clear, sizes go to 640 x 480; the line
// store has no clearing pass. the output register holds one result while the next item
// is accepted; a second result waits in the multiply stage until the first is taken.

module box_blur_3x3_rgb #(
    parameter int MAX_WIDTH = bbr_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bbr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bbr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    bbr_in_if.sink                         i_pix,
    bbr_out_if.source                      o_pix
);

    bbr_pkg::t_cmd    w_cmd;
    bbr_pkg::t_status w_status;
    logic             w_in_ready;
    logic             w_out_valid;
    logic [bbr_pkg::PIX_W-1:0] w_red, w_green, w_blue;
    logic             w_last;

    bbr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pix.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    bbr_dp #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_red        (i_pix.red_in),
        .i_green      (i_pix.green_in),
        .i_blue       (i_pix.blue_in),
        .i_flush      (i_pix.flush),
        .i_out_ready  (o_pix.ready),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .o_out_valid  (w_out_valid),
        .o_red        (w_red),
        .o_green      (w_green),
        .o_blue       (w_blue),
        .o_frame_last (w_last)
    );

    assign i_pix.ready      = w_in_ready;
    assign o_pix.valid      = w_out_valid;
    assign o_pix.red_out    = w_red;
    assign o_pix.green_out  = w_green;
    assign o_pix.blue_out   = w_blue;
    assign o_pix.frame_last = w_last;

endmodule

>>> tb/blur_checker.sv
`timescale 1ns / 1ps
// blur_checker: predicts the 3x3 box blur from the accepted input beats and compares the output beats
// keeps its own line rows, window, position counters and frame size; depends on bbr_pkg and the
// stream interfaces bbr_in_if and bbr_out_if

module blur_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bbr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bbr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    bbr_in_if                              i_pix,
    bbr_out_if                             i_res,
    output int                             o_mismatches,
    output int                             o_pending,
    output int                             o_checked
);

    localparam int MAX_W = bbr_pkg::MAX_WIDTH_DEFAULT;
    localparam int COL_W = $clog2(MAX_W);
    localparam int PW    = bbr_pkg::PIX_W;

    typedef struct packed {
        logic [PW-1:0] red;
        logic [PW-1:0] green;
        logic [PW-1:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [PW-1:0] red;
        logic [PW-1:0] green;
        logic [PW-1:0] blue;
        logic          frame_last;
    } t_blur_px;

    t_rgb                        line_rows [2*MAX_W];
    t_rgb                        nbhd [9];
    logic [COL_W-1:0]            in_col;
    logic [COL_W-1:0]            out_col;
    logic [bbr_pkg::IMG_H_W-1:0] in_row;
    logic [bbr_pkg::IMG_H_W-1:0] out_row;
    logic [bbr_pkg::IMG_W_W-1:0] width_reg;
    logic [bbr_pkg::IMG_H_W-1:0] height_reg;
    t_blur_px                    blur_q [$];
    int                          errs = 0;
    int                          n_checked = 0;

    function automatic void check_field(input string what, input logic [PW-1:0] want,
                                        input logic [PW-1:0] got);
        if (got !== want) begin
            $display("%0t blurred %s mismatch: expected %0d, got %0d", $time, what, want, got);
            errs++;
        end
    endfunction

    // one input beat: shift line rows and window, advance counters, queue the blurred pixel once primed
    function automatic void blur_accept(input t_rgb in_px, input logic fl);
        t_rgb     pix;
        t_rgb     upper;
        t_rgb     middle;
        t_rgb     v;
        int       w;
        int       h;
        int       col;
        int       n;
        int       sr;
        int       sg;
        int       sb;
        logic     primed;
        t_blur_px px;

        w = (width_reg == 0) ? 1 : (width_reg > MAX_W) ? MAX_W : int'(width_reg);
        h = (height_reg == 0) ? 1 : int'(height_reg);
        if (fl) begin
            pix = '0;
        end else begin
            pix = in_px;
        end

        col = int'(in_col);
        upper = line_rows[col];
        middle = line_rows[MAX_W + col];
        line_rows[col] = middle;
        line_rows[MAX_W + col] = pix;

        for (int rr = 0; rr < 3; rr++) begin
            nbhd[rr*3] = nbhd[rr*3 + 1];
            nbhd[rr*3 + 1] = nbhd[rr*3 + 2];
        end
        nbhd[2] = upper;
        nbhd[5] = middle;
        nbhd[8] = pix;

        primed = (in_row >= 2) || (in_row == 1 && in_col >= 1);

        if (int'(in_col) + 1 >= w) begin
            in_col = '0;
            if (in_row != '1) in_row = in_row + 1'b1;
        end else begin
            in_col = in_col + 1'b1;
        end

        if (!primed) return;

        n = 0;
        sr = 0;
        sg = 0;
        sb = 0;
        for (int rr = 0; rr < 3; rr++) begin
            if (rr == 0 && out_row == 0) continue;
            if (rr == 2 && int'(out_row) + 1 >= h) continue;
            for (int cc = 0; cc < 3; cc++) begin
                if (cc == 0 && out_col == 0) continue;
                if (cc == 2 && int'(out_col) + 1 >= w) continue;
                v = nbhd[rr*3 + cc];
                sr += v.red;
                sg += v.green;
                sb += v.blue;
                n++;
            end
        end
        if (n == 0) n = 1;

        px.red = PW'(sr / n);
        px.green = PW'(sg / n);
        px.blue = PW'(sb / n);
        px.frame_last = (int'(out_row) + 1 >= h) && (int'(out_col) + 1 >= w);
        blur_q.push_back(px);

        if (px.frame_last) begin
            in_col = '0;
            in_row = '0;
            out_col = '0;
            out_row = '0;
        end else if (int'(out_col) + 1 >= w) begin
            out_col = '0;
            out_row = out_row + 1'b1;
        end else begin
            out_col = out_col + 1'b1;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_blur_px want;

        if (!i_rst_n) begin
            in_col = '0;
            in_row = '0;
            out_col = '0;
            out_row = '0;
            width_reg = bbr_pkg::IMAGE_WIDTH_RESET;
            height_reg = bbr_pkg::IMAGE_HEIGHT_RESET;
            for (int k = 0; k < 9; k++) nbhd[k] = '0;
            blur_q.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (blur_q.size() == 0) begin
                    $display("%0t output beat with nothing queued: expected none, got %0d %0d %0d last %0d",
                             $time, i_res.red_out, i_res.green_out, i_res.blue_out,
                             i_res.frame_last);
                    errs++;
                end else begin
                    want = blur_q.pop_front();
                    check_field("red", want.red, i_res.red_out);
                    check_field("green", want.green, i_res.green_out);
                    check_field("blue", want.blue, i_res.blue_out);
                    check_field("frame_last", PW'(want.frame_last), PW'(i_res.frame_last));
                    n_checked++;
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == bbr_pkg::CFG_IMAGE_WIDTH) begin
                    width_reg = i_cfg_data[bbr_pkg::IMG_W_W-1:0];
                end else if (i_cfg_idx == bbr_pkg::CFG_IMAGE_HEIGHT) begin
                    height_reg = i_cfg_data[bbr_pkg::IMG_H_W-1:0];
                end
            end
            if (i_pix.valid && i_pix.ready) begin
                blur_accept({i_pix.red_in, i_pix.green_in, i_pix.blue_in}, i_pix.flush);
            end
        end
        o_pending <= blur_q.size();
        o_mismatches <= errs;
        o_checked <= n_checked;
    end

endmodule

>>> tb/tb_box_blur_3x3_rgb.sv
`timescale 1ns / 1ps
// tb_box_blur_3x3_rgb: stimulus and verdict for the streaming 3x3 rgb box blur
// sends whole frames at many sizes under idle gaps, output stalls and one long output hold;
// depends on bbr_pkg, bbr_in_if, bbr_out_if, blur_checker and box_blur_3x3_rgb

module tb_box_blur_3x3_rgb;

    localparam int RUN_LIMIT   = 100_000;
    localparam int SETTLE      = 12;
    localparam int HOLD_CYCLES = 300;
    localparam int RAND_BEATS  = 450;
    localparam int PW          = bbr_pkg::PIX_W;
    localparam int DW          = bbr_pkg::CFG_DATA_W;

    typedef enum int {
        PACE_FREE,
        PACE_TX_GAPS,
        PACE_RX_STALLS,
        PACE_BOTH
    } t_pace;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          cfg_we;
    logic [bbr_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [DW-1:0]                 cfg_data;
    int                            tx_idle_pct;
    int                            rx_stall_pct;
    logic                          rx_hold;
    event                          hold_kick;
    int                            beats_sent = 0;
    int                            sizes_run = 0;
    int                            cycles = 0;
    int                            mismatches;
    int                            pending;
    int                            checked;

    bbr_in_if  pix_in ();
    bbr_out_if pix_out ();

    box_blur_3x3_rgb dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_pix      (pix_in),
        .o_pix      (pix_out)
    );

    blur_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_pix        (pix_in),
        .i_res        (pix_out),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == RUN_LIMIT) begin
            $display("timeout after %0d cycles, %0d pixels still expected", cycles, pending);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // output side: random stalls, or a long hold while the input keeps offering beats
    initial begin
        pix_out.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold) begin
                pix_out.ready <= 1'b0;
            end else begin
                pix_out.ready <= ($urandom_range(99, 0) >= rx_stall_pct);
            end
        end
    end

    initial begin
        rx_hold <= 1'b0;
        forever begin
            @(hold_kick);
            rx_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            rx_hold <= 1'b0;
        end
    end

    task automatic send_beat(input logic [PW-1:0] r, g, b, input logic fl);
        while ($urandom_range(99, 0) < tx_idle_pct) begin
            pix_in.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_in.valid <= 1'b1;
        pix_in.red_in <= r;
        pix_in.green_in <= g;
        pix_in.blue_in <= b;
        pix_in.flush <= fl;
        @(posedge i_clk);
        while (!pix_in.ready) @(posedge i_clk);
        beats_sent++;
    endtask

    // a frame plus its drain; now and then the drain starts early or late
    task automatic send_frame(input int w, input int h);
        int   len;
        int   split;
        logic fl;

        len = w * h + w + 1;
        split = w * h;
        if ($urandom_range(3, 0) == 0) split = $urandom_range(len, 0);
        for (int k = 0; k < len; k++) begin
            if (k >= split) begin
                fl = ($urandom_range(4, 0) != 0);
            end else begin
                fl = ($urandom_range(9, 0) == 0);
            end
            send_beat(PW'($urandom_range(255, 0)), PW'($urandom_range(255, 0)),
                      PW'($urandom_range(255, 0)), fl);
        end
    endtask

    task automatic wait_drained();
        pix_in.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_size(input logic [DW-1:0] wd, hd);
        cfg_we <= 1'b1;
        cfg_idx <= bbr_pkg::CFG_IMAGE_WIDTH;
        cfg_data <= wd;
        @(posedge i_clk);
        cfg_idx <= bbr_pkg::CFG_IMAGE_HEIGHT;
        cfg_data <= hd;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
        sizes_run++;
    endtask

    task automatic run_phase(input logic [DW-1:0] wd, hd, input int frames,
                             input t_pace pace, input logic hold);
        int w;
        int h;

        w = (wd[bbr_pkg::IMG_W_W-1:0] == 0) ? 1 :
            (wd[bbr_pkg::IMG_W_W-1:0] > bbr_pkg::MAX_WIDTH_DEFAULT) ?
            bbr_pkg::MAX_WIDTH_DEFAULT : int'(wd[bbr_pkg::IMG_W_W-1:0]);
        h = (hd == 0) ? 1 : int'(hd);
        wait_drained();
        set_size(wd, hd);
        case (pace)
            PACE_FREE: begin
                tx_idle_pct = 0;
                rx_stall_pct <= 0;
            end
            PACE_TX_GAPS: begin
                tx_idle_pct = 46;
                rx_stall_pct <= 0;
            end
            PACE_RX_STALLS: begin
                tx_idle_pct = 0;
                rx_stall_pct <= 46;
            end
            default: begin
                tx_idle_pct = 36;
                rx_stall_pct <= 36;
            end
        endcase
        if (hold) -> hold_kick;
        for (int f = 0; f < frames; f++) send_frame(w, h);
    endtask

    initial begin : stimulus
        int            start;
        int            ph;
        logic [DW-1:0] wd;
        logic [DW-1:0] hd;

        i_rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_idx <= bbr_pkg::CFG_IMAGE_WIDTH;
        cfg_data <= '0;
        pix_in.valid <= 1'b0;
        pix_in.red_in <= '0;
        pix_in.green_in <= '0;
        pix_in.blue_in <= '0;
        pix_in.flush <= 1'b0;
        rx_stall_pct <= 0;
        tx_idle_pct = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // 3 x 2 frame: channel extremes, a black flush mid-frame, a real pixel in the drain
        set_size(16'd3, 16'd2);
        send_beat(8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_beat(8'h00, 8'h00, 8'h00, 1'b0);
        send_beat(8'hFF, 8'h00, 8'h80, 1'b0);
        send_beat(8'h7F, 8'hFF, 8'h01, 1'b0);
        send_beat(8'hAA, 8'h55, 8'hAA, 1'b1);
        send_beat(8'h55, 8'hAA, 8'hFE, 1'b0);
        send_beat(8'h00, 8'h00, 8'h00, 1'b1);
        send_beat(8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_beat(8'h00, 8'h00, 8'h00, 1'b1);
        send_beat(8'h00, 8'h00, 8'h00, 1'b1);
        wait_drained();

        // zero width and height both act as one
        set_size(16'd0, 16'd0);
        send_beat(8'hFF, 8'h80, 8'h01, 1'b0);
        send_beat(8'h12, 8'h34, 8'h56, 1'b1);
        send_beat(8'h00, 8'h00, 8'h00, 1'b1);

        start = beats_sent;
        ph = 0;
        while (beats_sent - start < RAND_BEATS) begin
            // upper data bits lie outside the width register and must be dropped
            wd = DW'($urandom_range(10, 1)) | DW'($urandom_range(31, 0) << 11);
            hd = DW'($urandom_range(6, 1));
            // the long hold needs enough results to fill the block
            if (ph == 2) begin
                wd = 16'd6;
                hd = 16'd4;
            end
            run_phase(wd, hd, $urandom_range(3, 1), t_pace'(ph % 4), ph == 2);
            ph++;
        end

        run_phase(16'd5, 16'd4, 2, PACE_BOTH, 1'b0);
        wait_drained();

        $display("sent %0d input beats over %0d frame sizes, up to 10 wide and 6 tall",
                 beats_sent, sizes_run);
        $display("compared %0d blurred pixels under input gaps, output stalls and a long hold",
                 checked);
        if (mismatches == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

>>> box_blur_3x3_rgb.f
sv/bbr_pkg.sv
sv/bbr_in_if.sv
sv/bbr_out_if.sv
sv/bbr_ram.sv
sv/bbr_ctrl.sv
sv/bbr_dp.sv
sv/box_blur_3x3_rgb.sv
tb/blur_checker.sv
tb/tb_box_blur_3x3_rgb.sv
